// ===== rtl/sdbs_pkg.sv =====
// ----------------------------------------------------------------------------
// Supply detect and brightness select package
// Shared widths, payload structs, register indexes and divider request type.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sdbs_pkg;

	localparam int WINDOW_DEPTH = 16;

	localparam int MV_W    = 13;
	localparam int AVG_W   = MV_W + 4;
	localparam int POS_W   = $clog2(WINDOW_DEPTH);
	localparam int CNT_W   = $clog2(WINDOW_DEPTH + 1);
	localparam int SUM_W   = $clog2(WINDOW_DEPTH * (2 ** MV_W));
	localparam int DIV_W   = SUM_W + 4;
	localparam int STEP_W  = $clog2(DIV_W);
	localparam int MS_W    = 4;
	localparam int CMP_W   = (CNT_W > MS_W) ? CNT_W : MS_W;
	localparam int DROP_W  = 16;
	localparam int LEVEL_W = 7;
	localparam int TX_W    = 3;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic KIND_SAMPLE = 1'b0;
	localparam logic KIND_QUERY  = 1'b1;

	localparam logic [TX_W-1:0] TX_LOWEST     = 3'd0;
	localparam logic [TX_W-1:0] TX_NORMAL_MIN = 3'd3;
	localparam logic [TX_W-1:0] TX_HIGHEST    = 3'd7;

	localparam logic [CFG_IDX_W-1:0] CFG_DISCONNECT_DROP = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_RECONNECT_DROP  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_SAMPLES     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_OFF       = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_LOW       = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_NORMAL    = 3'd5;

	localparam logic [DROP_W-1:0]  RST_DISCONNECT_DROP = 16'd400;
	localparam logic [DROP_W-1:0]  RST_RECONNECT_DROP  = 16'd240;
	localparam logic [MS_W-1:0]    RST_MIN_SAMPLES     = 4'd3;
	localparam logic [LEVEL_W-1:0] RST_LEVEL_OFF       = 7'd0;
	localparam logic [LEVEL_W-1:0] RST_LEVEL_LOW       = 7'd20;
	localparam logic [LEVEL_W-1:0] RST_LEVEL_NORMAL    = 7'd50;
	localparam logic [LEVEL_W-1:0] RST_LAST_BRIGHTNESS = 7'd50;

	typedef struct packed {
		logic            kind;
		logic [MV_W-1:0] sample_mv;
		logic [TX_W-1:0] tx_level;
	} in_t;

	typedef struct packed {
		logic               supply_present;
		logic [LEVEL_W-1:0] brightness;
		logic               brightness_changed;
		logic [AVG_W-1:0]   average_q4;
	} out_t;

	typedef struct packed {
		logic             start;
		logic [DIV_W-1:0] dividend;
		logic [CNT_W-1:0] divisor;
	} div_req_t;

endpackage

// ===== rtl/supply_detect_brightness_select.sv =====
// ----------------------------------------------------------------------------
// Supply detect and brightness select
// Transactions are accepted only in idle. A voltage sample gives no result;
// it updates the ring and running sum in ST_SAMPLE, then returns to idle.
// An evaluated query starts the bit-serial divider on acceptance and passes
// through ST_DIV to ST_JUDGE; one that is not evaluated goes straight there.
// ST_JUDGE registers the result once the output slot is free, then idles.
// Asynchronous reset restores control and state registers to their defaults.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module supply_detect_brightness_select (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  sdbs_pkg::in_t                     in_data,
	output logic                              out_valid,
	input  logic                              out_ready,
	output sdbs_pkg::out_t                    out_data,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [sdbs_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [sdbs_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import sdbs_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_SAMPLE = 4'b0010,
		ST_DIV    = 4'b0100,
		ST_JUDGE  = 4'b1000
	} state_t;

	state_t state_q;

	logic [DROP_W-1:0]  disc_drop_q;
	logic [DROP_W-1:0]  reco_drop_q;
	logic [MS_W-1:0]    min_samples_q;
	logic [LEVEL_W-1:0] level_off_q;
	logic [LEVEL_W-1:0] level_low_q;
	logic [LEVEL_W-1:0] level_normal_q;

	logic [MV_W-1:0]    ring [WINDOW_DEPTH];
	logic [MV_W-1:0]    ring_rd_q;
	logic [POS_W-1:0]   write_pos_q;
	logic               full_q;
	logic [SUM_W-1:0]   sum_q;
	logic [AVG_W-1:0]   peak_q;
	logic               seeded_q;
	logic               conn_q;
	logic [LEVEL_W-1:0] last_q;

	logic [MV_W-1:0]    mv_q;
	logic [TX_W-1:0]    tx_q;
	logic               eval_q;

	logic               out_valid_q;
	out_t               out_q;

	logic               accept;
	logic               slot_free;
	logic               eval_now;
	logic [CNT_W-1:0]   count_now;
	div_req_t           div_req;
	logic               div_done;
	logic [DIV_W-1:0]   div_quot;

	logic [AVG_W-1:0]   avg;
	logic [AVG_W-1:0]   peak_new;
	logic [AVG_W-1:0]   drop;
	logic               conn_next;
	logic               present;
	logic [LEVEL_W-1:0] bright;
	logic [SUM_W-1:0]   sum_next;

	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign cfg_ready = 1'b1;
	assign slot_free = !out_valid_q || out_ready;

	always_comb begin
		eval_now  = full_q ||
			((CMP_W'(write_pos_q) >= CMP_W'(min_samples_q)) && (write_pos_q != '0));
		count_now = full_q ? CNT_W'(WINDOW_DEPTH) : CNT_W'(write_pos_q);
		div_req.start    = accept && (in_data.kind == KIND_QUERY) && eval_now;
		div_req.dividend = {sum_q, 4'b0000};
		div_req.divisor  = count_now;
	end

	sdbs_divider u_divider (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (div_req),
		.done     (div_done),
		.quotient (div_quot)
	);

	always_comb begin
		avg      = eval_q ? div_quot[AVG_W-1:0] : '0;
		peak_new = (avg > peak_q) ? avg : peak_q;
		drop     = peak_new - avg;
		if (!eval_q) begin
			conn_next = conn_q;
		end else if (conn_q) begin
			conn_next = !(drop > AVG_W'(disc_drop_q));
		end else begin
			conn_next = (drop < AVG_W'(reco_drop_q));
		end
		present = eval_q ? conn_next : 1'b1;
		case (tx_q) inside
			[TX_NORMAL_MIN:TX_HIGHEST]: bright = level_normal_q;
			TX_LOWEST:                  bright = present ? level_low_q : level_off_q;
			default:                    bright = level_low_q;
		endcase
		sum_next = sum_q - (full_q ? SUM_W'(ring_rd_q) : '0) + SUM_W'(mv_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			disc_drop_q    <= RST_DISCONNECT_DROP;
			reco_drop_q    <= RST_RECONNECT_DROP;
			min_samples_q  <= RST_MIN_SAMPLES;
			level_off_q    <= RST_LEVEL_OFF;
			level_low_q    <= RST_LEVEL_LOW;
			level_normal_q <= RST_LEVEL_NORMAL;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_DISCONNECT_DROP: disc_drop_q    <= cfg_data;
				CFG_RECONNECT_DROP:  reco_drop_q    <= cfg_data;
				CFG_MIN_SAMPLES:     min_samples_q  <= cfg_data[MS_W-1:0];
				CFG_LEVEL_OFF:       level_off_q    <= cfg_data[LEVEL_W-1:0];
				CFG_LEVEL_LOW:       level_low_q    <= cfg_data[LEVEL_W-1:0];
				CFG_LEVEL_NORMAL:    level_normal_q <= cfg_data[LEVEL_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ring_rd_q <= ring[write_pos_q];
		end
		if (state_q == ST_SAMPLE) begin
			ring[write_pos_q] <= mv_q;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mv_q   <= in_data.sample_mv;
			tx_q   <= in_data.tx_level;
			eval_q <= eval_now;
		end
		if ((state_q == ST_JUDGE) && slot_free) begin
			out_q.supply_present     <= present;
			out_q.brightness         <= bright;
			out_q.brightness_changed <= (bright != last_q);
			out_q.average_q4         <= avg;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			write_pos_q <= '0;
			full_q      <= 1'b0;
			sum_q       <= '0;
			peak_q      <= '0;
			seeded_q    <= 1'b0;
			conn_q      <= 1'b1;
			last_q      <= RST_LAST_BRIGHTNESS;
			out_valid_q <= 1'b0;
		end else begin
			if ((state_q == ST_JUDGE) && slot_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (in_data.kind == KIND_SAMPLE) begin
							state_q <= ST_SAMPLE;
						end else if (eval_now) begin
							state_q <= ST_DIV;
						end else begin
							state_q <= ST_JUDGE;
						end
					end
				end
				ST_SAMPLE: begin
					if (!seeded_q) begin
						peak_q   <= {mv_q, 4'b0000};
						seeded_q <= 1'b1;
					end
					sum_q <= sum_next;
					if (write_pos_q == POS_W'(WINDOW_DEPTH - 1)) begin
						write_pos_q <= '0;
						full_q      <= 1'b1;
					end else begin
						write_pos_q <= write_pos_q + 1'b1;
					end
					state_q <= ST_IDLE;
				end
				ST_DIV: begin
					if (div_done) begin
						state_q <= ST_JUDGE;
					end
				end
				ST_JUDGE: begin
					if (slot_free) begin
						if (eval_q) begin
							peak_q <= peak_new;
							conn_q <= conn_next;
						end
						last_q  <= bright;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	a_sample_path: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (in_data.kind == KIND_SAMPLE)) |=> (state_q == ST_SAMPLE))
		else $error("Accepted sample did not enter the ring update.");

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		write_pos_q <= POS_W'(WINDOW_DEPTH - 1))
		else $error("Ring write position out of range.");

	a_sum_unseeded: assert property (@(posedge clk) disable iff (!arst_n)
		!seeded_q |-> ((sum_q == '0) && !full_q))
		else $error("Running sum moved before the first sample.");

	a_peak_tracks: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_JUDGE) && slot_free && eval_q) |=> (peak_q >= out_q.average_q4))
		else $error("Peak average fell below the reported average.");

endmodule

// ===== rtl/sdbs_divider.sv =====
// ----------------------------------------------------------------------------
// Serial restoring divider
// Produces one quotient bit per cycle; the quotient stays valid until the
// next start.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sdbs_divider (
	input  logic                    clk,
	input  logic                    arst_n,
	input  sdbs_pkg::div_req_t      req,
	output logic                    done,
	output logic [sdbs_pkg::DIV_W-1:0] quotient
);
	import sdbs_pkg::*;

	logic              busy_q;
	logic [STEP_W-1:0] step_q;
	logic [DIV_W-1:0]  dvd_q;
	logic [CNT_W-1:0]  rem_q;
	logic [CNT_W-1:0]  dsr_q;
	logic [CNT_W:0]    trial;
	logic [CNT_W:0]    diff;
	logic              qbit;

	always_comb begin
		trial = {rem_q, dvd_q[DIV_W-1]};
		diff  = trial - {1'b0, dsr_q};
		qbit  = (trial >= {1'b0, dsr_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			step_q <= STEP_W'(DIV_W - 1);
		end else if (busy_q) begin
			if (step_q == '0) begin
				busy_q <= 1'b0;
			end else begin
				step_q <= step_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q <= req.dividend;
			rem_q <= '0;
			dsr_q <= req.divisor;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[DIV_W-2:0], qbit};
			rem_q <= qbit ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
		end
	end

	assign done     = busy_q && (step_q == '0);
	assign quotient = dvd_q;

endmodule

// ===== tb/sdbs_checker.sv =====
// ----------------------------------------------------------------------------
// Supply detect and brightness select checker
// Watches the sample, query and register write channels. It keeps its own
// copy of the sample window, the peak average, the connect state and the
// last brightness. From these it works out the answer to each query and
// compares it, field by field, with each result transaction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sdbs_checker (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	input  logic                              in_ready,
	input  sdbs_pkg::in_t                     in_data,
	input  logic                              out_valid,
	input  logic                              out_ready,
	input  sdbs_pkg::out_t                    out_data,
	input  logic                              cfg_valid,
	input  logic                              cfg_ready,
	input  logic [sdbs_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [sdbs_pkg::CFG_DATA_W-1:0]   cfg_data,
	output int                                mismatches,
	output int                                pending,
	output int                                checked,
	output int                                battery_seen
);

	import sdbs_pkg::*;

	logic [DROP_W-1:0]  disc_drop;
	logic [DROP_W-1:0]  reconn_drop;
	logic [MS_W-1:0]    min_count;
	logic [LEVEL_W-1:0] lvl_off;
	logic [LEVEL_W-1:0] lvl_low;
	logic [LEVEL_W-1:0] lvl_normal;

	logic [MV_W-1:0]    mv_ring [WINDOW_DEPTH];
	logic [POS_W-1:0]   wr_pos;
	logic               ring_full;
	logic [SUM_W-1:0]   mv_sum;
	logic [AVG_W-1:0]   peak_q4;
	logic               peak_seeded;
	logic               on_mains;
	logic [LEVEL_W-1:0] prev_level;

	out_t answers_due [$];
	out_t answer;

	function automatic void take_mv(input logic [MV_W-1:0] mv);
		if (!peak_seeded) begin
			peak_q4 = {mv, 4'b0000};
			peak_seeded = 1'b1;
		end
		if (ring_full) begin
			mv_sum = mv_sum - SUM_W'(mv_ring[wr_pos]);
		end
		mv_ring[wr_pos] = mv;
		mv_sum = mv_sum + SUM_W'(mv);
		if (int'(wr_pos) == WINDOW_DEPTH - 1) begin
			wr_pos = '0;
			ring_full = 1'b1;
		end else begin
			wr_pos = wr_pos + 1'b1;
		end
	endfunction

	function automatic out_t answer_query(input logic [TX_W-1:0] tx);
		out_t        r;
		int unsigned held;
		int unsigned avg;
		int unsigned drop;
		logic        present;
		held = ring_full ? WINDOW_DEPTH : int'(wr_pos);
		avg = 0;
		if ((!ring_full && wr_pos < min_count) || held == 0) begin
			present = 1'b1;
		end else begin
			avg = (int'(mv_sum) * 16) / held;
			if (avg > int'(peak_q4)) begin
				peak_q4 = AVG_W'(avg);
			end
			drop = int'(peak_q4) - avg;
			if (on_mains) begin
				if (drop > int'(disc_drop)) on_mains = 1'b0;
			end else if (drop < int'(reconn_drop)) begin
				on_mains = 1'b1;
			end
			present = on_mains;
		end
		if (tx >= TX_NORMAL_MIN) begin
			r.brightness = lvl_normal;
		end else if (tx == TX_LOWEST && !present) begin
			r.brightness = lvl_off;
		end else begin
			r.brightness = lvl_low;
		end
		r.supply_present = present;
		r.brightness_changed = (r.brightness != prev_level);
		r.average_q4 = AVG_W'(avg);
		prev_level = r.brightness;
		return r;
	endfunction

	task automatic check_field(input string field, input int unsigned want,
		input int unsigned got);
		if (want != got) begin
			$display("%0t: %s expected %0d, got %0d", $time, field, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			disc_drop = RST_DISCONNECT_DROP;
			reconn_drop = RST_RECONNECT_DROP;
			min_count = RST_MIN_SAMPLES;
			lvl_off = RST_LEVEL_OFF;
			lvl_low = RST_LEVEL_LOW;
			lvl_normal = RST_LEVEL_NORMAL;
			wr_pos = '0;
			ring_full = 1'b0;
			mv_sum = '0;
			peak_q4 = '0;
			peak_seeded = 1'b0;
			on_mains = 1'b1;
			prev_level = RST_LAST_BRIGHTNESS;
			answers_due.delete();
			mismatches = 0;
			pending = 0;
			checked = 0;
			battery_seen = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (answers_due.size() == 0) begin
					$display("%0t: result with none expected: expected nothing, got %h",
						$time, out_data);
					mismatches++;
				end else begin
					answer = answers_due.pop_front();
					check_field("supply_present", int'(answer.supply_present),
						int'(out_data.supply_present));
					check_field("brightness", int'(answer.brightness),
						int'(out_data.brightness));
					check_field("brightness_changed", int'(answer.brightness_changed),
						int'(out_data.brightness_changed));
					check_field("average_q4", int'(answer.average_q4),
						int'(out_data.average_q4));
				end
				checked++;
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_DISCONNECT_DROP: disc_drop = cfg_data;
					CFG_RECONNECT_DROP:  reconn_drop = cfg_data;
					CFG_MIN_SAMPLES:     min_count = cfg_data[MS_W-1:0];
					CFG_LEVEL_OFF:       lvl_off = cfg_data[LEVEL_W-1:0];
					CFG_LEVEL_LOW:       lvl_low = cfg_data[LEVEL_W-1:0];
					CFG_LEVEL_NORMAL:    lvl_normal = cfg_data[LEVEL_W-1:0];
					default: ;
				endcase
			end
			if (in_valid && in_ready) begin
				if (in_data.kind == KIND_SAMPLE) begin
					take_mv(in_data.sample_mv);
				end else begin
					answer = answer_query(in_data.tx_level);
					if (!answer.supply_present) battery_seen++;
					answers_due.push_back(answer);
				end
			end
			pending = answers_due.size();
		end
	end

endmodule

// ===== tb/tb_supply_detect_brightness_select.sv =====
// ----------------------------------------------------------------------------
// Supply detect and brightness select testbench
// Runs a short directed sequence through the empty window, the too few
// samples case, the peak seeding, a supply loss and a reconnection, then
// random phases of battery traces near full scale mixed with random noise.
// Each phase uses its own register setting; the idling patterns repeat every four phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_supply_detect_brightness_select;

	import sdbs_pkg::*;

	localparam int CLK_PERIOD      = 10;
	localparam int RESET_CYCLES    = 9;
	localparam int LATENCY         = DIV_W + 2;
	localparam int ITEM_TARGET     = 1550;
	localparam int PHASES          = 8;
	localparam int PRESSURE_PHASE  = 4;
	localparam int HOLD_CYCLES     = 400;
	localparam int WATCHDOG_CYCLES = 1000000;
	localparam int MV_TOP          = 2 ** MV_W - 1;
	localparam int REG_SLOTS       = 2 ** CFG_IDX_W;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	in_t                   in_data = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	out_t                  out_data;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	int mismatches;
	int pending;
	int checked;
	int battery_seen;

	int   send_idle_pct = 0;
	int   recv_stall_pct = 0;
	logic hold_off = 1'b0;
	int   dip_mv = 0;
	int   sent_items = 0;
	int   queries_sent = 0;

	logic [CFG_DATA_W-1:0] reg_val [REG_SLOTS];

	always #(CLK_PERIOD / 2) clk = ~clk;

	supply_detect_brightness_select i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	sdbs_checker i_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.in_data      (in_data),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.out_data     (out_data),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.mismatches   (mismatches),
		.pending      (pending),
		.checked      (checked),
		.battery_seen (battery_seen)
	);

	always @(posedge clk) begin
		out_ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
	end

	task automatic hold_receiver(input int cycles);
		hold_off <= 1'b1;
		repeat (cycles) @(posedge clk);
		hold_off <= 1'b0;
	endtask

	task automatic send_item(input in_t item);
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		in_valid <= 1'b1;
		in_data <= item;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sent_items++;
		if (item.kind == KIND_QUERY) queries_sent++;
	endtask

	task automatic offer(input logic kind, input int unsigned mv, input int unsigned tx);
		in_t item;
		item.kind = kind;
		item.sample_mv = MV_W'(mv);
		item.tx_level = TX_W'(tx);
		send_item(item);
	endtask

	// Samples follow a battery trace a few hundred millivolts below full scale,
	// so the drop from the peak wanders across the hysteresis thresholds.
	task automatic make_item(output in_t item);
		int roll;
		roll = $urandom_range(99);
		item.kind = KIND_QUERY;
		item.sample_mv = MV_W'($urandom);
		item.tx_level = TX_W'($urandom);
		if (roll < 6) begin
			item.kind = 1'($urandom_range(1));
		end else if (roll >= 35) begin
			item.kind = KIND_SAMPLE;
			if ($urandom_range(31) == 0) begin
				dip_mv = $urandom_range(300);
			end else begin
				dip_mv += int'($urandom_range(12)) - 6;
			end
			if (dip_mv < 0) dip_mv = 0;
			if (dip_mv > 500) dip_mv = 500;
			item.sample_mv = MV_W'(MV_TOP - dip_mv - int'($urandom_range(3)));
		end
	endtask

	task automatic load_regs();
		for (int i = 0; i < REG_SLOTS; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= CFG_IDX_W'(i);
			cfg_data <= reg_val[i];
			@(posedge clk);
			while (!cfg_ready) @(posedge clk);
		end
		cfg_valid <= 1'b0;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (2 * LATENCY) @(posedge clk);
	endtask

	task automatic pick_settings(input int phase);
		for (int i = 0; i < REG_SLOTS; i++) begin
			reg_val[i] = CFG_DATA_W'($urandom);
		end
		if (phase == 0) begin
			reg_val[CFG_DISCONNECT_DROP] = RST_DISCONNECT_DROP;
			reg_val[CFG_RECONNECT_DROP] = RST_RECONNECT_DROP;
			reg_val[CFG_MIN_SAMPLES] = CFG_DATA_W'(RST_MIN_SAMPLES);
			reg_val[CFG_LEVEL_OFF] = CFG_DATA_W'(RST_LEVEL_OFF);
			reg_val[CFG_LEVEL_LOW] = CFG_DATA_W'(RST_LEVEL_LOW);
			reg_val[CFG_LEVEL_NORMAL] = CFG_DATA_W'(RST_LEVEL_NORMAL);
		end else if (phase == 1) begin
			reg_val[CFG_DISCONNECT_DROP] = '0;
			reg_val[CFG_RECONNECT_DROP] = '0;
			reg_val[CFG_MIN_SAMPLES] = '0;
			reg_val[CFG_LEVEL_OFF] = CFG_DATA_W'(100);
			reg_val[CFG_LEVEL_LOW] = CFG_DATA_W'(100);
			reg_val[CFG_LEVEL_NORMAL] = CFG_DATA_W'(100);
		end else if (phase == 2) begin
			reg_val[CFG_DISCONNECT_DROP] = '1;
			reg_val[CFG_RECONNECT_DROP] = '1;
			reg_val[CFG_MIN_SAMPLES] = '1;
			reg_val[CFG_LEVEL_OFF] = '1;
			reg_val[CFG_LEVEL_LOW] = '1;
			reg_val[CFG_LEVEL_NORMAL] = '1;
		end else begin
			reg_val[CFG_DISCONNECT_DROP] = CFG_DATA_W'($urandom_range(3000));
			reg_val[CFG_RECONNECT_DROP] = CFG_DATA_W'($urandom_range(3000));
			if ($urandom_range(3) != 0) begin
				reg_val[CFG_LEVEL_OFF] = CFG_DATA_W'($urandom_range(100));
				reg_val[CFG_LEVEL_LOW] = CFG_DATA_W'($urandom_range(100));
				reg_val[CFG_LEVEL_NORMAL] = CFG_DATA_W'($urandom_range(100));
			end
		end
	endtask

	initial begin
		in_t item;
		for (int i = 0; i < REG_SLOTS; i++) begin
			reg_val[i] = CFG_DATA_W'($urandom);
		end
		reg_val[CFG_DISCONNECT_DROP] = RST_DISCONNECT_DROP;
		reg_val[CFG_RECONNECT_DROP] = RST_RECONNECT_DROP;
		reg_val[CFG_LEVEL_OFF] = CFG_DATA_W'(RST_LEVEL_OFF);
		reg_val[CFG_LEVEL_LOW] = CFG_DATA_W'(RST_LEVEL_LOW);
		reg_val[CFG_LEVEL_NORMAL] = CFG_DATA_W'(RST_LEVEL_NORMAL);

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// A query with no sample held at all reports the supply as present.
		reg_val[CFG_MIN_SAMPLES] = '0;
		load_regs();
		offer(KIND_QUERY, 0, TX_LOWEST);
		offer(KIND_QUERY, MV_TOP, TX_HIGHEST);
		drain();

		reg_val[CFG_MIN_SAMPLES] = CFG_DATA_W'(2);
		load_regs();
		offer(KIND_SAMPLE, 0, TX_HIGHEST);
		offer(KIND_QUERY, 0, 1);
		offer(KIND_SAMPLE, MV_TOP, TX_LOWEST);
		offer(KIND_QUERY, 0, TX_LOWEST);
		offer(KIND_QUERY, 0, TX_NORMAL_MIN);
		offer(KIND_SAMPLE, 0, 5);
		offer(KIND_QUERY, 0, TX_LOWEST);
		offer(KIND_QUERY, 0, 2);
		drain();

		// A wide reconnect window brings the supply back, then the window
		// fills and the peak rises again.
		reg_val[CFG_RECONNECT_DROP] = '1;
		load_regs();
		offer(KIND_QUERY, MV_TOP, TX_LOWEST);
		repeat (WINDOW_DEPTH - 3) offer(KIND_SAMPLE, MV_TOP, 6);
		offer(KIND_QUERY, 0, 6);
		offer(KIND_QUERY, MV_TOP, TX_LOWEST);
		drain();

		for (int phase = 0; phase < PHASES; phase++) begin
			pick_settings(phase);
			load_regs();
			send_idle_pct = (phase % 4 == 1) ? 88 : (phase % 4 == 3) ? 14 : 0;
			recv_stall_pct = (phase % 4 == 2) ? 88 : (phase % 4 == 3) ? 14 : 0;
			if (phase == PRESSURE_PHASE) begin
				fork
					hold_receiver(HOLD_CYCLES);
				join_none
			end
			repeat (ITEM_TARGET / PHASES) begin
				make_item(item);
				send_item(item);
			end
			drain();
		end

		$display("Sent %0d transactions, %0d of them brightness queries, under %0d register settings.",
			sent_items, queries_sent, PHASES + 3);
		$display("Compared %0d results; %0d evaluated queries judged the supply lost.",
			checked, battery_seen);
		if (mismatches == 0 && pending == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

	initial begin
		#(CLK_PERIOD * WATCHDOG_CYCLES);
		$display("Timed out with %0d results still outstanding.", pending);
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/sdbs_pkg.sv
rtl/sdbs_divider.sv
rtl/supply_detect_brightness_select.sv
tb/sdbs_checker.sv
tb/tb_supply_detect_brightness_select.sv
